>>> rtl/core/tlpq_pkg.sv
// Shared types, constants and helpers for the three-level priority queue.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package tlpq_pkg;

    // Storage depth and the widths that follow from it.
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the request and response beats.
    localparam int MODE_W   = 2;
    localparam int ID_W     = 32;
    localparam int WEIGHT_W = 16;
    localparam int RANK_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Priority codes.
    localparam logic [RANK_W-1:0] RANK_NONE   = 2'd0;
    localparam logic [RANK_W-1:0] RANK_HIGH   = 2'd1;
    localparam logic [RANK_W-1:0] RANK_MEDIUM = 2'd2;
    localparam logic [RANK_W-1:0] RANK_LOW    = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_PEEK     = 2'd2,
        MODE_SEARCH   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADRANK  = 3'd4
    } status_t;

    // Controller state.
    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_SEARCH = 1'b1
    } fsm_state_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_INSERT    = 2'd1,
        CELL_SHIFT_OUT = 2'd2,
        CELL_COMPARE   = 2'd3
    } cell_op_t;

    // One stored entry.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
        logic [RANK_W-1:0]   rank;
    } slot_t;

    // Broadcast control from the controller to the cells.
    typedef struct packed {
        cell_op_t          op;
        slot_t             new_slot;
        logic [ID_W-1:0]   key;
    } cell_ctrl_t;

    // Resize an internal count to the width of the count fields.
    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, c};
        return wide[COUNT_W-1:0];
    endfunction

endpackage

>>> rtl/core/tlpq_if.sv
// Request and response channel interfaces of the three-level priority queue.
// Depends on tlpq_pkg for the field widths.
interface tlpq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [tlpq_pkg::MODE_W-1:0]          mode;
    logic signed [tlpq_pkg::ID_W-1:0]     parcel_id;
    logic [tlpq_pkg::WEIGHT_W-1:0]        weight_centikg;
    logic [tlpq_pkg::RANK_W-1:0]          rank;

    modport source(output valid, mode, parcel_id, weight_centikg, rank, input ready);
    modport sink(input valid, mode, parcel_id, weight_centikg, rank, output ready);
endinterface

interface tlpq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [tlpq_pkg::STATUS_W-1:0]        status;
    logic signed [tlpq_pkg::ID_W-1:0]     entry_id;
    logic [tlpq_pkg::WEIGHT_W-1:0]        entry_weight;
    logic [tlpq_pkg::RANK_W-1:0]          entry_rank;
    logic [tlpq_pkg::COUNT_W-1:0]         count_high;
    logic [tlpq_pkg::COUNT_W-1:0]         count_medium;
    logic [tlpq_pkg::COUNT_W-1:0]         count_low;

    modport source(output valid, status, entry_id, entry_weight, entry_rank,
                   count_high, count_medium, count_low, input ready);
    modport sink(input valid, status, entry_id, entry_weight, entry_rank,
                 count_high, count_medium, count_low, output ready);
endinterface

>>> rtl/core/tlpq_cell.sv
// One slot of the sorted chain: holds an entry, its valid bit and a search hit flag.
// Depends on tlpq_pkg; instantiated in a row by three_level_priority_queue.
module tlpq_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlpq_pkg::cell_ctrl_t          ctrl,
    input  tlpq_pkg::slot_t               prev_slot,
    input  logic                          prev_valid,
    input  logic                          prev_ins,
    input  tlpq_pkg::slot_t               next_slot,
    input  logic                          next_valid,
    output tlpq_pkg::slot_t               slot,
    output logic                          valid,
    output logic                          ins,
    output logic                          hit
);

    tlpq_pkg::slot_t slot_reg;
    tlpq_pkg::slot_t slot_next;
    logic            valid_reg;
    logic            valid_next;
    logic            hit_reg;
    logic            hit_next;

    // This slot lies at or behind the insertion point of the new entry.
    // The store stays sorted by rank, so the flag is monotonic along the chain.
    always_comb
    begin
        if (!valid_reg)
            ins = 1'b1;
        else
            ins = (ctrl.new_slot.rank == tlpq_pkg::RANK_HIGH) ||
                  (slot_reg.rank > ctrl.new_slot.rank);
    end

    // Next contents: take the neighbor's entry, the new entry, or keep; a compare updates the hit flag.
    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        case (ctrl.op)
            tlpq_pkg::CELL_INSERT:
            begin
                if (ins && prev_ins)
                begin
                    slot_next  = prev_slot;
                    valid_next = prev_valid;
                end
                else if (ins)
                begin
                    slot_next  = ctrl.new_slot;
                    valid_next = 1'b1;
                end
            end
            tlpq_pkg::CELL_SHIFT_OUT:
            begin
                slot_next  = next_slot;
                valid_next = next_valid;
            end
            tlpq_pkg::CELL_COMPARE:
            begin
                hit_next = valid_reg && (slot_reg.id == ctrl.key);
            end
            default:
            begin
                slot_next  = slot_reg;
                valid_next = valid_reg;
                hit_next   = hit_reg;
            end
        endcase
    end

    // Entry payload carries no reset.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign slot  = slot_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

>>> rtl/core/three_level_priority_queue.sv
// Three-level priority queue built as a chain of QUEUE_DEPTH slot cells.
// Add, dispatch and peek: the result is in the output register in the cycle after the beat is taken.
// Search: the cells register their compare flags, then the first hit is selected into the output register.
// Add, dispatch and peek take one beat per cycle while no response is held back; no beat is taken during a search.
// Reset clears the valid bits, the rank counters, the controller and the response valid flag.
// Depends on tlpq_pkg, tlpq_if (tlpq_req_if, tlpq_rsp_if) and tlpq_cell.
module three_level_priority_queue (
    input  logic            clk,
    input  logic            rst_n,
    tlpq_req_if.sink        req,
    tlpq_rsp_if.source      rsp
);

    localparam int DEPTH = tlpq_pkg::QUEUE_DEPTH;

    tlpq_pkg::fsm_state_t   state_reg;
    tlpq_pkg::fsm_state_t   state_next;

    logic [tlpq_pkg::CNT_W-1:0] cnt_high_reg;
    logic [tlpq_pkg::CNT_W-1:0] cnt_high_next;
    logic [tlpq_pkg::CNT_W-1:0] cnt_medium_reg;
    logic [tlpq_pkg::CNT_W-1:0] cnt_medium_next;
    logic [tlpq_pkg::CNT_W-1:0] cnt_low_reg;
    logic [tlpq_pkg::CNT_W-1:0] cnt_low_next;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    tlpq_pkg::status_t          rsp_status_reg;
    tlpq_pkg::status_t          rsp_status_next;
    tlpq_pkg::slot_t            rsp_slot_reg;
    tlpq_pkg::slot_t            rsp_slot_next;
    logic [tlpq_pkg::CNT_W-1:0] rsp_high_reg;
    logic [tlpq_pkg::CNT_W-1:0] rsp_medium_reg;
    logic [tlpq_pkg::CNT_W-1:0] rsp_low_reg;

    tlpq_pkg::slot_t        slot_vec [DEPTH];
    logic [DEPTH-1:0]       valid_vec;
    logic [DEPTH-1:0]       ins_vec;
    logic [DEPTH-1:0]       hit_vec;
    logic [DEPTH-1:0]       first_hit;
    tlpq_pkg::slot_t        hit_slot;

    tlpq_pkg::cell_ctrl_t   ctrl;
    tlpq_pkg::mode_t        req_mode;
    logic                   accept;
    logic                   in_ready;
    logic                   search_done;
    logic                   rsp_load;
    logic                   store_full;
    logic                   store_empty;
    tlpq_pkg::status_t      step_status;
    tlpq_pkg::slot_t        step_slot;

    // Row of slot cells; apart from the broadcast control, each one talks only to its neighbors.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tlpq_pkg::slot_t prev_slot;
        logic            prev_valid;
        logic            prev_ins;
        tlpq_pkg::slot_t next_slot;
        logic            next_valid;

        if (i == 0)
        begin : g_head
            assign prev_slot  = '0;
            assign prev_valid = 1'b0;
            assign prev_ins   = 1'b0;
        end
        else
        begin : g_body
            assign prev_slot  = slot_vec[i-1];
            assign prev_valid = valid_vec[i-1];
            assign prev_ins   = ins_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_slot  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_mid
            assign next_slot  = slot_vec[i+1];
            assign next_valid = valid_vec[i+1];
        end

        tlpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_slot  (prev_slot),
            .prev_valid (prev_valid),
            .prev_ins   (prev_ins),
            .next_slot  (next_slot),
            .next_valid (next_valid),
            .slot       (slot_vec[i]),
            .valid      (valid_vec[i]),
            .ins        (ins_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlpq_pkg::FSM_IDLE:
            begin
                if (accept && (req_mode == tlpq_pkg::MODE_SEARCH))
                    state_next = tlpq_pkg::FSM_SEARCH;
            end
            tlpq_pkg::FSM_SEARCH:
                state_next = tlpq_pkg::FSM_IDLE;
            default:
                state_next = tlpq_pkg::FSM_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        search_done = 1'b0;
        case (state_reg)
            tlpq_pkg::FSM_IDLE:
                in_ready = !rsp_valid_reg || rsp.ready;
            tlpq_pkg::FSM_SEARCH:
                search_done = 1'b1;
            default:
            begin
                in_ready    = 1'b0;
                search_done = 1'b0;
            end
        endcase
    end

    assign req.ready   = in_ready;
    assign accept      = req.valid && in_ready;
    assign req_mode    = tlpq_pkg::mode_t'(req.mode);
    assign store_full  = valid_vec[DEPTH-1];
    assign store_empty = !valid_vec[0];

    // Decode the request beat into a chain operation, a status and counter updates.
    always_comb
    begin
        ctrl.op                = tlpq_pkg::CELL_HOLD;
        ctrl.new_slot.id       = $unsigned(req.parcel_id);
        ctrl.new_slot.weight   = req.weight_centikg;
        ctrl.new_slot.rank     = req.rank;
        ctrl.key               = $unsigned(req.parcel_id);
        step_status            = tlpq_pkg::ST_OK;
        step_slot              = '0;
        cnt_high_next          = cnt_high_reg;
        cnt_medium_next        = cnt_medium_reg;
        cnt_low_next           = cnt_low_reg;
        if (accept)
        begin
            case (req_mode)
                tlpq_pkg::MODE_ADD:
                begin
                    if (req.rank == tlpq_pkg::RANK_NONE)
                        step_status = tlpq_pkg::ST_BADRANK;
                    else if (store_full)
                        step_status = tlpq_pkg::ST_FULL;
                    else
                    begin
                        ctrl.op = tlpq_pkg::CELL_INSERT;
                        if (req.rank == tlpq_pkg::RANK_HIGH)
                            cnt_high_next = cnt_high_reg + tlpq_pkg::CNT_ONE;
                        else if (req.rank == tlpq_pkg::RANK_MEDIUM)
                            cnt_medium_next = cnt_medium_reg + tlpq_pkg::CNT_ONE;
                        else
                            cnt_low_next = cnt_low_reg + tlpq_pkg::CNT_ONE;
                    end
                end
                tlpq_pkg::MODE_DISPATCH,
                tlpq_pkg::MODE_PEEK:
                begin
                    if (store_empty)
                        step_status = tlpq_pkg::ST_EMPTY;
                    else
                    begin
                        step_slot = slot_vec[0];
                        if (req_mode == tlpq_pkg::MODE_DISPATCH)
                        begin
                            ctrl.op = tlpq_pkg::CELL_SHIFT_OUT;
                            if (slot_vec[0].rank == tlpq_pkg::RANK_HIGH)
                                cnt_high_next = cnt_high_reg - tlpq_pkg::CNT_ONE;
                            else if (slot_vec[0].rank == tlpq_pkg::RANK_MEDIUM)
                                cnt_medium_next = cnt_medium_reg - tlpq_pkg::CNT_ONE;
                            else
                                cnt_low_next = cnt_low_reg - tlpq_pkg::CNT_ONE;
                        end
                    end
                end
                tlpq_pkg::MODE_SEARCH:
                    ctrl.op = tlpq_pkg::CELL_COMPARE;
                default:
                    ctrl.op = tlpq_pkg::CELL_HOLD;
            endcase
        end
    end

    // Pick the hit nearest the front among the registered compare flags.
    assign first_hit = hit_vec & (~hit_vec + {{(DEPTH-1){1'b0}}, 1'b1});

    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_hit[i])
                hit_slot = hit_slot | slot_vec[i];
        end
    end

    // Output register: loaded by a non-search beat or in the search state.
    assign rsp_load = (accept && (req_mode != tlpq_pkg::MODE_SEARCH)) || search_done;

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = step_status;
        rsp_slot_next   = step_slot;
        if (search_done)
        begin
            if (hit_vec != '0)
            begin
                rsp_status_next = tlpq_pkg::ST_OK;
                rsp_slot_next   = hit_slot;
            end
            else
            begin
                rsp_status_next = tlpq_pkg::ST_NOTFOUND;
                rsp_slot_next   = '0;
            end
        end
        if (rsp_load)
            rsp_valid_next = 1'b1;
    end

    // Response payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_slot_reg   <= rsp_slot_next;
            rsp_high_reg   <= cnt_high_next;
            rsp_medium_reg <= cnt_medium_next;
            rsp_low_reg    <= cnt_low_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlpq_pkg::FSM_IDLE;
            rsp_valid_reg  <= 1'b0;
            cnt_high_reg   <= '0;
            cnt_medium_reg <= '0;
            cnt_low_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            cnt_high_reg   <= cnt_high_next;
            cnt_medium_reg <= cnt_medium_next;
            cnt_low_reg    <= cnt_low_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.entry_id     = rsp_slot_reg.id;
    assign rsp.entry_weight = rsp_slot_reg.weight;
    assign rsp.entry_rank   = rsp_slot_reg.rank;
    assign rsp.count_high   = tlpq_pkg::to_count(rsp_high_reg);
    assign rsp.count_medium = tlpq_pkg::to_count(rsp_medium_reg);
    assign rsp.count_low    = tlpq_pkg::to_count(rsp_low_reg);

    // Occupied slots always form an unbroken run from the front.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + {{(DEPTH-1){1'b0}}, 1'b1})) == '0)
        else $error("occupied slots are not a prefix of the chain");

    // The rank counters add up to the number of occupied slots.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({2'b00, cnt_high_reg} + {2'b00, cnt_medium_reg} + {2'b00, cnt_low_reg})
            == (tlpq_pkg::CNT_W + 2)'($countones(valid_vec)))
        else $error("rank counters disagree with occupied slots");

    // A search beat always finishes with a response once the search state has loaded the output register.
    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_mode == tlpq_pkg::MODE_SEARCH)) |=> ##1 rsp_valid_reg)
        else $error("search did not produce a response");

    // No new beat is taken while a response is held back.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !in_ready)
        else $error("request taken while response stalled");

endmodule
